/* src/fdk_pkg.sv */
// Shared types and constants for the keep-two-of-three FIR decimator.
// Holds sample and accumulator widths and the fixed Q15 tap weights.
// No dependencies.
package fdk_pkg;

  localparam int TAP_COUNT = 15;
  localparam int SAMPLE_W  = 16;
  localparam int COEF_W    = 16;
  localparam int PROD_W    = SAMPLE_W + COEF_W;
  // The sum of tap magnitudes is 14032, so any partial sum fits in 30 signed bits.
  localparam int ACC_W     = 30;
  localparam int FRAC_W    = 15;

  localparam int SAT_MAX   = 32767;
  localparam int SAT_MIN   = -32768;

  typedef logic signed [SAMPLE_W-1:0] sample_t;
  typedef logic signed [COEF_W-1:0]   coef_t;
  typedef logic signed [ACC_W-1:0]    acc_t;

  // Symmetric low-pass taps, tap 0 meets the newest sample.
  localparam coef_t COEF [TAP_COUNT] = '{
    -16'sd98, -16'sd212, 16'sd0, 16'sd687, 16'sd0, -16'sd1966, 16'sd0, 16'sd8106,
    16'sd0, -16'sd1966, 16'sd0, 16'sd687, 16'sd0, -16'sd212, -16'sd98
  };

  // Handover from the cell row to the output register.
  typedef struct packed {
    logic load;
    acc_t sum;
  } fdk_load_t;

endpackage

/* src/fdk_cell.sv */
// One cell of the transposed-form filter row: multiply the broadcast sample
// by this cell's tap weight and add the partial sum from the older neighbor.
// Depends on fdk_pkg.
module fdk_cell (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           adv_i,
  input  fdk_pkg::sample_t sample_i,
  input  fdk_pkg::coef_t coef_i,
  input  fdk_pkg::acc_t  sum_i,
  output fdk_pkg::acc_t  sum_o
);
  import fdk_pkg::*;

  logic signed [PROD_W-1:0] prod;
  acc_t sum_r;
  acc_t sum_nxt;

  // Product of the new sample and the tap, plus the neighbor's partial sum.
  assign prod    = PROD_W'(sample_i) * PROD_W'(coef_i);
  assign sum_nxt = $signed(prod[ACC_W-1:0]) + sum_i;

  // The partial sum moves only when an item is taken.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sum_r <= '0;
    end else if (adv_i) begin
      sum_r <= sum_nxt;
    end
  end

  assign sum_o = sum_r;

endmodule

/* src/fdk_out.sv */
// Output stage: floor shift of the full sum by the fraction width, clamp to
// the sample range, and hold the result until the receiver takes it.
// Depends on fdk_pkg.
module fdk_out (
  input  logic              clk,
  input  logic              rst_n,
  input  fdk_pkg::fdk_load_t load_i,
  input  logic              out_stall,
  output logic              free_o,
  output logic              out_valid,
  output fdk_pkg::sample_t  out_sample_out
);
  import fdk_pkg::*;

  acc_t    shifted;
  sample_t sat;
  logic    valid_r;
  logic    valid_nxt;
  sample_t data_r;

  // Arithmetic shift rounds toward minus infinity, then saturate.
  assign shifted = load_i.sum >>> FRAC_W;

  always_comb begin
    if (shifted > ACC_W'(SAT_MAX)) begin
      sat = SAMPLE_W'(SAT_MAX);
    end else if (shifted < ACC_W'(SAT_MIN)) begin
      sat = SAMPLE_W'(SAT_MIN);
    end else begin
      sat = shifted[SAMPLE_W-1:0];
    end
  end

  // The register can take a new item when empty or when its item leaves.
  assign free_o = !valid_r || !out_stall;

  always_comb begin
    if (load_i.load) begin
      valid_nxt = 1'b1;
    end else if (!out_stall) begin
      valid_nxt = 1'b0;
    end else begin
      valid_nxt = valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load_i.load) begin
      data_r <= sat;
    end
  end

  assign out_valid      = valid_r;
  assign out_sample_out = data_r;

endmodule

/* src/fir_decimate_keep_two_of_three_core.sv */
// 15-tap Q15 low-pass filter that keeps two samples out of every three.
// Throughput: one item per cycle while in_stall is low; the row of cells updates every accepted cycle.
// A kept item's sum is registered in cell 0, then in the output register once it is free, and is offered from there.
// Phase 2 items update the cells but produce no result.
// Reset (synchronous, active low) clears all partial sums, the phase and the output valid flag.
// Depends on fdk_pkg, fdk_cell and fdk_out.
module fir_decimate_keep_two_of_three_core (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_stall,
  input  fdk_pkg::sample_t in_sample_in,
  output logic             out_valid,
  input  logic             out_stall,
  output fdk_pkg::sample_t out_sample_out
);
  import fdk_pkg::*;

  localparam logic [1:0] PH_0 = 2'd0;
  localparam logic [1:0] PH_1 = 2'd1;
  localparam logic [1:0] PH_2 = 2'd2;

  logic      accept;
  logic      free;
  logic      take;
  logic [1:0] phase_r;
  logic [1:0] phase_nxt;
  logic      emit;
  logic      fresh_r;
  logic      fresh_nxt;
  acc_t      sums [TAP_COUNT+1];
  fdk_load_t load;

  // The newest sum sits in cell 0 until the output register takes it.
  assign take     = fresh_r && free;
  assign in_stall = fresh_r && !free;
  assign accept   = in_valid && !in_stall;

  // Row of cells, oldest tap at the far end fed with zero.
  assign sums[TAP_COUNT] = '0;

  for (genvar k = 0; k < TAP_COUNT; k++) begin : g_cell
    fdk_cell u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .adv_i    (accept),
      .sample_i (in_sample_in),
      .coef_i   (COEF[k]),
      .sum_i    (sums[k+1]),
      .sum_o    (sums[k])
    );
  end

  // Phase counter picks which items produce a result.
  assign emit = (phase_r == PH_0) || (phase_r == PH_1);

  always_comb begin
    unique case (phase_r)
      PH_0:    phase_nxt = PH_1;
      PH_1:    phase_nxt = PH_2;
      default: phase_nxt = PH_0;
    endcase
  end

  always_comb begin
    if (accept) begin
      fresh_nxt = emit;
    end else if (take) begin
      fresh_nxt = 1'b0;
    end else begin
      fresh_nxt = fresh_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_0;
      fresh_r <= 1'b0;
    end else begin
      if (accept) begin
        phase_r <= phase_nxt;
      end
      fresh_r <= fresh_nxt;
    end
  end

  // Output register with shift and clamp.
  assign load = '{load: take, sum: sums[0]};

  fdk_out u_out (
    .clk            (clk),
    .rst_n          (rst_n),
    .load_i         (load),
    .out_stall      (out_stall),
    .free_o         (free),
    .out_valid      (out_valid),
    .out_sample_out (out_sample_out)
  );

endmodule

/* test/tb_top.sv */
// Testbench for the keep-two-of-three 15-tap FIR decimator core.
// Predicts every kept sample from its own model of the filter and checks the output stream.
// Depends on fdk_pkg and fir_decimate_keep_two_of_three_core.
`timescale 1ns / 1ps

module tb_top;
  import fdk_pkg::*;

  localparam int NUM_TAPS    = 15;
  localparam int Q15_SHIFT   = 15;
  localparam int CYCLE_LIMIT = 300000;
  localparam int TAIL_CYCLES = 10;

  logic    clk;
  logic    rst_n        = 1'b0;
  logic    in_valid     = 1'b0;
  logic    in_stall;
  sample_t in_sample_in = '0;
  logic    out_valid;
  logic    out_stall    = 1'b0;
  sample_t out_sample_out;

  // Model of the filter state: newest sample at index 0.
  sample_t  sample_hist [NUM_TAPS];
  logic [1:0] decim_phase;
  sample_t  kept_samples [$];

  int  errors           = 0;
  int  cycle_count      = 0;
  bit  tx_idle_on       = 1'b0;
  bit  rx_idle_on       = 1'b0;
  int  hold_cycles_left = 0;
  int  rx_burst_left    = 0;

  fir_decimate_keep_two_of_three_core i_dut (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_sample_in  (in_sample_in),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_sample_out(out_sample_out)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
  end

  // Symmetric low-pass weights, tap 0 meets the newest sample.
  function automatic int tap_weight(input int idx);
    case (idx)
      0, 14:   return -98;
      1, 13:   return -212;
      3, 11:   return 687;
      5, 9:    return -1966;
      7:       return 8106;
      default: return 0;
    endcase
  endfunction

  // Shift one accepted item into the model and queue its output if the phase keeps it.
  task automatic predict_filter(input sample_t s);
    longint sum;
    longint scaled;
    sum = 0;
    for (int i = NUM_TAPS - 1; i > 0; i--) begin
      sample_hist[i] = sample_hist[i-1];
    end
    sample_hist[0] = s;
    for (int i = 0; i < NUM_TAPS; i++) begin
      sum += longint'(sample_hist[i]) * longint'(tap_weight(i));
    end
    scaled = sum >>> Q15_SHIFT;
    if (scaled > 32767) scaled = 32767;
    if (scaled < -32768) scaled = -32768;
    if (decim_phase == 2'd0 || decim_phase == 2'd1) begin
      kept_samples.push_back(sample_t'(scaled[15:0]));
    end
    decim_phase = (decim_phase >= 2'd2) ? 2'd0 : decim_phase + 2'd1;
  endtask

  // Offer one item, wait for it to be taken, then maybe idle for a burst.
  task automatic send_sample(input sample_t s);
    int gap;
    @(negedge clk);
    in_valid     <= 1'b1;
    in_sample_in <= s;
    do @(posedge clk); while (in_stall);
    predict_filter(s);
    if (tx_idle_on && $urandom_range(0, 5) == 0) begin
      gap = $urandom_range(1, 11);
      @(negedge clk);
      in_valid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
  endtask

  task automatic stop_sending();
    @(negedge clk);
    in_valid <= 1'b0;
  endtask

  task automatic wait_for_drain();
    while (kept_samples.size() != 0) @(posedge clk);
  endtask

  // Mostly full-range values, with a share of small values and values near the rails.
  function automatic sample_t random_sample();
    case ($urandom_range(0, 9))
      0:       return $urandom_range(0, 1) ? sample_t'(32767 - $urandom_range(0, 15))
                                           : sample_t'(-32768 + $urandom_range(0, 15));
      1, 2:    return sample_t'($urandom_range(0, 511) - 256);
      default: return sample_t'($urandom_range(0, 65535));
    endcase
  endfunction

  // Receiver: long hold-offs on request, otherwise random stall bursts.
  always @(negedge clk) begin
    if (hold_cycles_left > 0) begin
      out_stall <= 1'b1;
      hold_cycles_left--;
    end else if (rx_burst_left > 0) begin
      out_stall <= 1'b1;
      rx_burst_left--;
    end else if (rx_idle_on && $urandom_range(0, 7) == 0) begin
      out_stall <= 1'b1;
      rx_burst_left = $urandom_range(1, 11) - 1;
    end else begin
      out_stall <= 1'b0;
    end
  end

  // Compare each taken result with the oldest kept sample.
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (kept_samples.size() == 0) begin
        $display("%0t: unexpected sample_out %0d with none expected", $time, out_sample_out);
        errors++;
      end else begin
        if (out_sample_out !== kept_samples[0]) begin
          $display("%0t: sample_out mismatch: expected %0d, got %0d",
                   $time, kept_samples[0], out_sample_out);
          errors++;
        end
        void'(kept_samples.pop_front());
      end
    end
  end

  // An impulse at full scale walks through every tap, including dropped phases.
  task automatic test_impulse_response();
    send_sample(sample_t'(32767));
    repeat (NUM_TAPS - 1) send_sample('0);
    stop_sending();
  endtask

  // Rails, sign boundaries and alternating bit patterns.
  task automatic test_field_extremes();
    send_sample(sample_t'(-32768));
    send_sample(sample_t'(32767));
    send_sample(sample_t'(-1));
    send_sample(sample_t'(1));
    send_sample(16'sh5555);
    send_sample(16'shAAAA);
    send_sample(sample_t'(32767));
    send_sample(sample_t'(-32768));
    stop_sending();
  endtask

  task automatic test_random_stream(input int count);
    tx_idle_on = 1'b1;
    rx_idle_on = 1'b1;
    repeat (count) send_sample(random_sample());
    stop_sending();
  endtask

  // Receiver holds off long enough for the core to fill and stall its input,
  // then the sender pauses until every kept sample has been taken.
  task automatic test_backpressure();
    tx_idle_on = 1'b0;
    rx_idle_on = 1'b0;
    @(posedge clk);
    hold_cycles_left = 300;
    repeat (60) send_sample(random_sample());
    stop_sending();
    wait_for_drain();
    rx_idle_on = 1'b1;
    tx_idle_on = 1'b1;
    repeat (40) send_sample(random_sample());
    stop_sending();
  endtask

  // Back-to-back items with no stalls at the end of the run.
  task automatic test_quiet_tail(input int count);
    tx_idle_on = 1'b0;
    rx_idle_on = 1'b0;
    repeat (count) send_sample(random_sample());
    stop_sending();
  endtask

  initial begin
    for (int i = 0; i < NUM_TAPS; i++) sample_hist[i] = '0;
    decim_phase = 2'd0;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_impulse_response();
    test_field_extremes();
    test_random_stream(1700);
    test_backpressure();
    test_quiet_tail(200);

    wait_for_drain();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (kept_samples.size() != 0) begin
      $display("%0t: %0d expected samples never arrived", $time, kept_samples.size());
      errors++;
    end
    if (errors == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

  // Watchdog for a hung handshake.
  initial begin
    wait (cycle_count >= CYCLE_LIMIT);
    $display("%0t: timeout after %0d cycles", $time, cycle_count);
    $display("Simulation FAILED");
    $finish;
  end

endmodule
